/* design/tsbc_pkg.sv */
// Shared types and constants for the touch stroke bitmap capture block.
// Holds the transaction structs, the state and capture codes and the image sizes.
// No dependencies; every other file imports this package.
package tsbc_pkg;

    // Image size and derived index widths
    localparam int IMG_WIDTH  = 70;
    localparam int IMG_HEIGHT = 70;
    localparam int COL_W      = $clog2(IMG_WIDTH);
    localparam int ROW_W      = $clog2(IMG_HEIGHT);

    // Fixed field widths
    localparam int RAW_W  = 12;
    localparam int SPAN_W = 13;
    localparam int TMO_W  = 16;
    localparam int TIME_W = 32;
    localparam int DL_W   = 33;

    // Scaling datapath: quotient magnitude bits kept, numerator magnitude bits
    localparam int Q_W    = 8;
    localparam int QK_W   = $clog2(Q_W);
    localparam int MAG_W  = RAW_W + 7;
    localparam int DIV_W  = SPAN_W + Q_W;
    localparam int CTR_W  = Q_W + 2;

    // Axis slots of the scaler: raw x gives the row, raw y gives the column
    localparam int AX_ROW = 0;
    localparam int AX_COL = 1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd4;

    // Command kinds
    localparam logic [1:0] KIND_POLL = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_FREE = 2'd2;

    typedef enum logic [1:0] {
        CAP_FREE  = 2'd0,
        CAP_DIRTY = 2'd1,
        CAP_READY = 2'd2
    } t_cap;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_CENTER,
        ST_RD,
        ST_WR,
        ST_PIX
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic        pen_down;
        logic [11:0] raw_x;
        logic [11:0] raw_y;
        logic [31:0] now_ms;
        logic [6:0]  read_col;
        logic [6:0]  read_row;
    } t_cmd;

    typedef struct packed {
        logic       image_ready;
        logic       pixel_value;
        logic [1:0] capture_state_code;
    } t_result;

endpackage

/* design/touch_stroke_bitmap_capture.sv */
// Touch stroke bitmap capture: top level with the row memory and the stamp sequencer.
// Depends on tsbc_pkg for types and constants.
//
// Usage:
//   Command channel: drive i_cmd and raise start; the transaction is taken at a
//   rising edge where start is high and busy is low. Each transaction yields one
//   result on o_result, marked by o_done for exactly one cycle; the receiver
//   cannot stall, so it must take the result in that cycle.
//   Free, pen-up polls, polls while ready and unused kinds report in the cycle
//   after acceptance and leave busy low. A pixel read reports after one memory
//   read, through the ST_PIX state. A pen-down poll outside ready runs a setup
//   step, the shift-subtract scaler (one quotient bit per cycle for both axes),
//   a step to build the column mask, then a read and a write of each image row
//   touched by the 3x3 stamp, and reports once the last row is done.
//   A new transaction is taken only while busy is low; the row memory port and
//   the scaler set how long a pen-down poll keeps busy high.
//   Configuration: write i_cfg_wdata to register i_cfg_idx with i_cfg_we, only
//   while no transaction is in flight.
//   Reset (synchronous, active low): state free, deadline zero, registers at
//   their defaults, every row valid bit cleared so the image reads as blank.
//   Free clears every row valid bit together when it is accepted; the row memory itself is never swept.
module touch_stroke_bitmap_capture
    import tsbc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  t_cmd                  i_cmd,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                  busy,
    output logic                  o_done,
    output t_result               o_result
);

    // Configuration registers
    logic [RAW_W-1:0]  r_origin_x, r_origin_y;
    logic [SPAN_W-1:0] r_span_x, r_span_y;
    logic [TMO_W-1:0]  r_timeout;

    // Control state
    t_state            r_state, n_state;
    t_cap              r_cap, n_cap;
    logic [DL_W-1:0]   r_deadline, n_deadline;
    logic [IMG_HEIGHT-1:0] r_row_vld;
    logic              n_done;
    t_result           n_result;
    logic              r_done;
    t_result           r_result;

    // Latched command and scaler
    t_cmd              r_cmd;
    logic [MAG_W-1:0]  r_rem  [2];
    logic [Q_W-1:0]    r_q    [2];
    logic              r_neg  [2];
    logic              r_ovf  [2];
    logic [SPAN_W-1:0] r_spn  [2];
    logic [QK_W-1:0]   r_div_k;

    // Stamp sequencer
    logic [IMG_WIDTH-1:0] r_colmask;
    logic [CTR_W-1:0]  r_row_base;
    logic              r_row_off;
    logic [1:0]        r_row_k;
    logic [ROW_W-1:0]  r_waddr;

    // Row memory
    logic [IMG_WIDTH-1:0] r_mem [IMG_HEIGHT];
    logic [IMG_WIDTH-1:0] r_rdata;
    logic              r_rd_vld;
    logic              mem_re, mem_we;
    logic [ROW_W-1:0]  mem_raddr;
    logic [IMG_WIDTH-1:0] mem_wdata;

    // Pixel read
    logic              r_rd_ok;
    logic [COL_W-1:0]  r_col;

    // Combinational helpers
    logic [RAW_W:0]    prep_d   [2];
    logic [RAW_W-1:0]  prep_abs [2];
    logic [MAG_W-1:0]  prep_mag [2];
    logic [SPAN_W-1:0] prep_spn [2];
    logic              prep_ovf [2];
    logic [RAW_W-1:0]  prep_raw [2];
    logic [RAW_W-1:0]  prep_org [2];
    logic [SPAN_W-1:0] prep_span[2];
    logic [DIV_W-1:0]  div_sh   [2];
    logic              div_ge   [2];
    logic [MAG_W-1:0]  div_diff [2];
    logic [CTR_W-1:0]  ctr_q    [2];
    logic [CTR_W-1:0]  ctr      [2];
    logic [IMG_WIDTH-1:0] colmask;
    logic [CTR_W-1:0]  col_diff [IMG_WIDTH];
    logic [CTR_W-1:0]  row_cur;
    logic              row_hit;
    logic              accept;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign o_done   = r_done;
    assign o_result = r_result;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_span_x   <= SPAN_W'(4096);
            r_span_y   <= SPAN_W'(4096);
            r_timeout  <= TMO_W'(1000);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ORIGIN_X: r_origin_x <= i_cfg_wdata[RAW_W-1:0];
                CFG_ORIGIN_Y: r_origin_y <= i_cfg_wdata[RAW_W-1:0];
                CFG_SPAN_X:   r_span_x   <= i_cfg_wdata[SPAN_W-1:0];
                CFG_SPAN_Y:   r_span_y   <= i_cfg_wdata[SPAN_W-1:0];
                CFG_TIMEOUT:  r_timeout  <= i_cfg_wdata[TMO_W-1:0];
                default: ;
            endcase
        end
    end

    // Scaler setup: offset, magnitude, times the image size, and an early check
    // for quotients too large to land anywhere near the image.
    assign prep_raw[AX_ROW]  = r_cmd.raw_x;
    assign prep_raw[AX_COL]  = r_cmd.raw_y;
    assign prep_org[AX_ROW]  = r_origin_x;
    assign prep_org[AX_COL]  = r_origin_y;
    assign prep_span[AX_ROW] = r_span_x;
    assign prep_span[AX_COL] = r_span_y;

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            prep_d[a]   = {1'b0, prep_raw[a]} - {1'b0, prep_org[a]};
            prep_abs[a] = prep_d[a][RAW_W] ? RAW_W'(~prep_d[a] + 1'b1)
                                           : prep_d[a][RAW_W-1:0];
            prep_mag[a] = (a == AX_ROW) ? MAG_W'(prep_abs[a] * IMG_HEIGHT)
                                        : MAG_W'(prep_abs[a] * IMG_WIDTH);
            // a zero span divides as a span of one
            prep_spn[a] = (prep_span[a] == '0) ? SPAN_W'(1) : prep_span[a];
            prep_ovf[a] = {(DIV_W-MAG_W)'(0), prep_mag[a]} >= {prep_spn[a], Q_W'(0)};
        end
    end

    // One restoring step per cycle on both axes
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            div_sh[a]   = {Q_W'(0), r_spn[a]} << r_div_k;
            div_ge[a]   = {(DIV_W-MAG_W)'(0), r_rem[a]} >= div_sh[a];
            div_diff[a] = r_rem[a] - div_sh[a][MAG_W-1:0];
        end
    end

    // Signed centers and the 3-wide column mask of the stamp
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            ctr_q[a] = {2'b00, r_q[a]};
            ctr[a]   = r_neg[a] ? (~ctr_q[a] + 1'b1) : ctr_q[a];
        end
        for (int c = 0; c < IMG_WIDTH; c++) begin
            col_diff[c] = ctr[AX_COL] - CTR_W'(c);
            colmask[c]  = !r_ovf[AX_COL] &&
                          (col_diff[c] == {CTR_W{1'b1}} ||
                           col_diff[c] == CTR_W'(0) ||
                           col_diff[c] == CTR_W'(1));
        end
    end

    // Current stamp row and whether it falls on the image
    assign row_cur = r_row_base + CTR_W'(r_row_k);
    assign row_hit = !r_row_off && !row_cur[CTR_W-1] && (row_cur < CTR_W'(IMG_HEIGHT));

    // Merge the stamp into the row; a row never written since the last clear reads blank
    assign mem_wdata = (r_rd_vld ? r_rdata : '0) | r_colmask;

    // Next state, memory control and result
    always_comb begin
        n_state    = r_state;
        n_cap      = r_cap;
        n_deadline = r_deadline;
        n_done     = 1'b0;
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        mem_raddr  = '0;
        n_result.pixel_value = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_done = 1'b1;
                    unique case (i_cmd.kind)
                        KIND_POLL: begin
                            if (r_cap != CAP_READY) begin
                                if (i_cmd.pen_down) begin
                                    // commit the state now, report after the stamp
                                    n_cap      = CAP_DIRTY;
                                    n_deadline = {1'b0, i_cmd.now_ms} + DL_W'(r_timeout);
                                    n_state    = ST_PREP;
                                    n_done     = 1'b0;
                                end else if (r_cap == CAP_DIRTY &&
                                             {1'b0, i_cmd.now_ms} > r_deadline) begin
                                    n_cap = CAP_READY;
                                end
                            end
                        end
                        KIND_READ: begin
                            mem_re    = ({1'b0, i_cmd.read_row} < 8'(IMG_HEIGHT));
                            mem_raddr = i_cmd.read_row[ROW_W-1:0];
                            n_state   = ST_PIX;
                            n_done    = 1'b0;
                        end
                        KIND_FREE: begin
                            n_cap = CAP_FREE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PREP: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_div_k == '0) begin
                    n_state = ST_CENTER;
                end
            end
            ST_CENTER: begin
                n_state = ST_RD;
            end
            ST_RD: begin
                if (row_hit) begin
                    mem_re    = 1'b1;
                    mem_raddr = row_cur[ROW_W-1:0];
                    n_state   = ST_WR;
                end else if (r_row_k == 2'd2) begin
                    n_state = ST_IDLE;
                    n_done  = 1'b1;
                end
            end
            ST_WR: begin
                mem_we = 1'b1;
                if (r_row_k == 2'd2) begin
                    n_state = ST_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_PIX: begin
                n_state = ST_IDLE;
                n_done  = 1'b1;
                n_result.pixel_value = r_rd_ok ? (r_rd_vld & r_rdata[r_col]) : 1'b0;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_result.image_ready        = (n_cap == CAP_READY);
        n_result.capture_state_code = n_cap;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cap      <= CAP_FREE;
            r_deadline <= '0;
            r_done     <= 1'b0;
            r_row_vld  <= '0;
        end else begin
            r_state    <= n_state;
            r_cap      <= n_cap;
            r_deadline <= n_deadline;
            r_done     <= n_done;
            if (accept && i_cmd.kind == KIND_FREE) begin
                r_row_vld <= '0;
            end else if (mem_we) begin
                r_row_vld[r_waddr] <= 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (n_done) begin
            r_result <= n_result;
        end
    end

    // Row memory: one read port with registered data, one write port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata  <= r_mem[mem_raddr];
            r_rd_vld <= r_row_vld[mem_raddr];
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= i_cmd;
            r_rd_ok <= (r_cap == CAP_READY) &&
                       ({1'b0, i_cmd.read_col} < 8'(IMG_WIDTH)) &&
                       ({1'b0, i_cmd.read_row} < 8'(IMG_HEIGHT));
            r_col   <= i_cmd.read_col[COL_W-1:0];
        end

        unique case (r_state)
            ST_PREP: begin
                for (int a = 0; a < 2; a++) begin
                    r_rem[a] <= prep_mag[a];
                    r_q[a]   <= '0;
                    r_neg[a] <= prep_d[a][RAW_W];
                    r_ovf[a] <= prep_ovf[a];
                    r_spn[a] <= prep_spn[a];
                end
                r_div_k <= QK_W'(Q_W - 1);
            end
            ST_DIV: begin
                for (int a = 0; a < 2; a++) begin
                    if (div_ge[a]) begin
                        r_rem[a]         <= div_diff[a];
                        r_q[a][r_div_k]  <= 1'b1;
                    end
                end
                r_div_k <= r_div_k - 1'b1;
            end
            ST_CENTER: begin
                r_colmask  <= colmask;
                r_row_base <= ctr[AX_ROW] - 1'b1;
                r_row_off  <= r_ovf[AX_ROW];
                r_row_k    <= 2'd0;
            end
            ST_RD: begin
                // hold the row index for the write; skip rows off the image
                r_waddr <= row_cur[ROW_W-1:0];
                if (!row_hit) begin
                    r_row_k <= r_row_k + 1'b1;
                end
            end
            ST_WR: begin
                r_row_k <= r_row_k + 1'b1;
            end
            default: ;
        endcase
    end

endmodule

/* design/tsbc_checker.sv */
// Port-level checks for the touch stroke bitmap capture block, bound to the top level.
// Depends on tsbc_pkg and on touch_stroke_bitmap_capture.
module tsbc_checker
    import tsbc_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_done,
    input t_result o_result
);

    // An accepted transaction either reports next cycle or keeps the block busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_done || busy))
        else $error("accepted transaction neither reported nor held busy");

    // Results only appear once the block is free again
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_ready_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.image_ready == (o_result.capture_state_code == CAP_READY)))
        else $error("image_ready disagrees with state code");

    a_pixel_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.pixel_value) |-> o_result.image_ready)
        else $error("pixel returned while image not ready");

    a_no_done_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !start) |=> !o_done)
        else $error("result without a transaction");

endmodule

bind touch_stroke_bitmap_capture tsbc_checker u_tsbc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

/* tb/sv/touch_stroke_bitmap_capture_test.sv */
`timescale 1ns / 1ps
// Self-checking test for touch_stroke_bitmap_capture: command transactions with random gaps,
// results predicted by a behavioral model of the capture logic and compared field by field.
// Depends on tsbc_pkg and the touch_stroke_bitmap_capture RTL.
module touch_stroke_bitmap_capture_test;
    import tsbc_pkg::*;

    localparam int          CYCLE_LIMIT   = 300000;
    localparam int          PHASE_ITEMS   = 170;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          MAX_GAP       = 11;
    localparam logic [1:0]  KIND_UNUSED   = 2'd3;

    // Behavioral model of the capture state, the image and the pending results.
    class stroke_tracker;
        logic [11:0]          org_x, org_y;
        logic [12:0]          span_x, span_y;
        logic [15:0]          tmo;
        logic [IMG_WIDTH-1:0] img [IMG_HEIGHT];
        t_cap                 cap_state;
        logic [32:0]          deadline;
        t_result              due_results[$];
        int                   errors;

        function new();
            org_x     = '0;
            org_y     = '0;
            span_x    = 13'd4096;
            span_y    = 13'd4096;
            tmo       = 16'd1000;
            cap_state = CAP_FREE;
            deadline  = '0;
            errors    = 0;
            clear_image();
        endfunction

        function void clear_image();
            foreach (img[r]) img[r] = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_ORIGIN_X: org_x  = val[11:0];
                CFG_ORIGIN_Y: org_y  = val[11:0];
                CFG_SPAN_X:   span_x = val[12:0];
                CFG_SPAN_Y:   span_y = val[12:0];
                CFG_TIMEOUT:  tmo    = val;
                default: ;
            endcase
        endfunction

        // Signed quotient, truncated toward zero; a zero span counts as one.
        function int scale_axis(int raw, int origin, int span, int size);
            int d;
            int s;
            d = raw - origin;
            s = (span == 0) ? 1 : span;
            return (size * d) / s;
        endfunction

        // Drop any part of the pen square that falls off the image.
        function void stamp_pixel(int c, int r);
            if (c >= 0 && c < IMG_WIDTH && r >= 0 && r < IMG_HEIGHT)
                img[r][c] = 1'b1;
        endfunction

        function t_result apply_command(t_cmd c);
            int      col, row, di, dj;
            logic    pix;
            t_result r;
            pix = 1'b0;
            case (c.kind)
                KIND_POLL: begin
                    // Polls while ready are ignored entirely.
                    if (cap_state != CAP_READY) begin
                        if (c.pen_down) begin
                            col = scale_axis(c.raw_y, org_y, span_y, IMG_WIDTH);
                            row = scale_axis(c.raw_x, org_x, span_x, IMG_HEIGHT);
                            for (di = -1; di <= 1; di++)
                                for (dj = -1; dj <= 1; dj++)
                                    stamp_pixel(col + dj, row + di);
                            cap_state = CAP_DIRTY;
                            deadline  = {1'b0, c.now_ms} + {17'd0, tmo};
                        end else if (cap_state == CAP_DIRTY && {1'b0, c.now_ms} > deadline) begin
                            cap_state = CAP_READY;
                        end
                    end
                end
                KIND_READ: begin
                    if (cap_state == CAP_READY && c.read_col < IMG_WIDTH
                            && c.read_row < IMG_HEIGHT)
                        pix = img[c.read_row][c.read_col];
                end
                KIND_FREE: begin
                    // The deadline keeps its value across a free.
                    clear_image();
                    cap_state = CAP_FREE;
                end
                default: ;
            endcase
            r.image_ready        = (cap_state == CAP_READY);
            r.pixel_value        = pix;
            r.capture_state_code = cap_state;
            return r;
        endfunction

        function void note_command(t_cmd c);
            due_results.push_back(apply_command(c));
        endfunction

        task report(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                report("result strobe with no transaction outstanding");
                return;
            end
            want = due_results.pop_front();
            if (got.image_ready !== want.image_ready)
                report($sformatf("image_ready got %0b want %0b",
                                 got.image_ready, want.image_ready));
            if (got.pixel_value !== want.pixel_value)
                report($sformatf("pixel_value got %0b want %0b",
                                 got.pixel_value, want.pixel_value));
            if (got.capture_state_code !== want.capture_state_code)
                report($sformatf("capture_state_code got %0d want %0d",
                                 got.capture_state_code, want.capture_state_code));
        endtask

        task check_drained();
            if (due_results.size() != 0)
                report($sformatf("%0d results never arrived", due_results.size()));
        endtask
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    t_cmd                  i_cmd       = '0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  busy;
    logic                  o_done;
    t_result               o_result;

    stroke_tracker tracker = new();
    int            cycle_count = 0;
    int            sent = 0;
    int            cfg_regs [5];
    logic [31:0]   clock_ms = '0;
    bit            burst = 1'b0;

    touch_stroke_bitmap_capture u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_cmd       (i_cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .busy        (busy),
        .o_done      (o_done),
        .o_result    (o_result)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Check the result first: a transaction taken at this edge cannot report at it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                tracker.check_result(o_result);
            if (start && !busy)
                tracker.note_command(i_cmd);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("touch_stroke_bitmap_capture: mismatch");
            $finish;
        end
    end

    function automatic t_cmd make_cmd(logic [1:0] kind, logic pen, logic [11:0] x,
                                      logic [11:0] y, logic [31:0] now,
                                      logic [6:0] col, logic [6:0] row);
        t_cmd c;
        c.kind     = kind;
        c.pen_down = pen;
        c.raw_x    = x;
        c.raw_y    = y;
        c.now_ms   = now;
        c.read_col = col;
        c.read_row = row;
        return c;
    endfunction

    // Raw sample that lands near pixel t on an axis with the given origin and span.
    function automatic logic [11:0] raw_for(int t, int org, int span, int size);
        int s;
        int raw;
        s   = (span == 0) ? 1 : span;
        raw = org + (2 * t * s + s) / (2 * size);
        if (raw < 0)
            raw = 0;
        if (raw > 4095)
            raw = 4095;
        return raw[11:0];
    endfunction

    // Hold start across back-to-back transactions; drop it only for a real gap.
    task automatic send_cmd(t_cmd c);
        int gap;
        gap = burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        sent++;
    endtask

    task automatic poll(logic pen, logic [11:0] x, logic [11:0] y, logic [31:0] now);
        send_cmd(make_cmd(KIND_POLL, pen, x, y, now, 7'($urandom), 7'($urandom)));
    endtask

    task automatic read_px(int col, int row);
        send_cmd(make_cmd(KIND_READ, 1'($urandom), 12'($urandom), 12'($urandom), $urandom,
                          col[6:0], row[6:0]));
    endtask

    task automatic free_img();
        send_cmd(make_cmd(KIND_FREE, 1'($urandom), 12'($urandom), 12'($urandom), $urandom,
                          7'($urandom), 7'($urandom)));
    endtask

    // Hold off the sender until every outstanding result is back.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.due_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        tracker.set_reg(idx, val[CFG_DATA_W-1:0]);
        cfg_regs[idx] = val;
    endtask

    task automatic load_settings(int ox, int oy, int sx, int sy, int tmo);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_SPAN_X, sx);
        write_reg(CFG_SPAN_Y, sy);
        write_reg(CFG_TIMEOUT, tmo);
        i_cfg_we <= 1'b0;
    endtask

    // One stroke: pen-down polls along a short path, pen-up around the deadline,
    // reads near the stroke once ready, then usually a free.
    task automatic draw_stroke();
        int          tc, tr, n, k, off;
        longint      up_ms;
        logic [31:0] down_ms;
        tc = $urandom_range(0, IMG_WIDTH + 3) - 2;
        tr = $urandom_range(0, IMG_HEIGHT + 3) - 2;
        n  = $urandom_range(1, 6);
        down_ms = clock_ms;
        for (k = 0; k < n; k++) begin
            clock_ms = clock_ms + $urandom_range(0, 40);
            down_ms  = clock_ms;
            poll(1'b1,
                 raw_for(tr, cfg_regs[CFG_ORIGIN_X], cfg_regs[CFG_SPAN_X], IMG_HEIGHT),
                 raw_for(tc, cfg_regs[CFG_ORIGIN_Y], cfg_regs[CFG_SPAN_Y], IMG_WIDTH),
                 clock_ms);
            tc = tc + $urandom_range(0, 4) - 2;
            tr = tr + $urandom_range(0, 4) - 2;
        end
        // Early pen-up, not yet past the deadline.
        if ($urandom_range(0, 2) == 0)
            poll(1'b0, 12'($urandom), 12'($urandom),
                 down_ms + $urandom_range(0, cfg_regs[CFG_TIMEOUT]));
        off   = $urandom_range(0, 2);
        up_ms = longint'(down_ms) + cfg_regs[CFG_TIMEOUT] + off;
        if (up_ms > 64'hFFFF_FFFF)
            up_ms = 64'hFFFF_FFFF;
        clock_ms = up_ms[31:0];
        poll(1'b0, 12'($urandom), 12'($urandom), clock_ms);
        // Exactly at the deadline is not past it; step one more millisecond.
        if (off == 0) begin
            clock_ms = clock_ms + 1;
            poll(1'b0, 12'($urandom), 12'($urandom), clock_ms);
        end
        if ($urandom_range(0, 3) == 0)
            poll(1'($urandom), 12'($urandom), 12'($urandom),
                 clock_ms + $urandom_range(0, 99999));
        repeat ($urandom_range(3, 10))
            read_px(tc + $urandom_range(0, 4) - 2, tr + $urandom_range(0, 4) - 2);
        if ($urandom_range(0, 4) == 0)
            read_px($urandom_range(0, 127), $urandom_range(0, 127));
        if ($urandom_range(0, 5) != 0)
            free_img();
        // Now and then jump the clock, sometimes right up to the top of its range.
        if ($urandom_range(0, 9) == 0)
            clock_ms = $urandom_range(0, 5000);
        else if ($urandom_range(0, 24) == 0)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 70000);
    endtask

    task automatic noise_burst();
        logic [95:0] bits;
        repeat ($urandom_range(1, 4)) begin
            bits = {$urandom, $urandom, $urandom};
            send_cmd(t_cmd'(bits[$bits(t_cmd)-1:0]));
        end
    endtask

    task automatic run_phase(int ox, int oy, int sx, int sy, int tmo);
        int goal;
        drain();
        load_settings(ox, oy, sx, sy, tmo);
        goal = sent + PHASE_ITEMS;
        while (sent < goal) begin
            burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0)
                noise_burst();
            else
                draw_stroke();
            if ($urandom_range(0, 15) == 0)
                drain();
        end
    endtask

    initial begin
        cfg_regs[CFG_ORIGIN_X] = 0;
        cfg_regs[CFG_ORIGIN_Y] = 0;
        cfg_regs[CFG_SPAN_X]   = 4096;
        cfg_regs[CFG_SPAN_Y]   = 4096;
        cfg_regs[CFG_TIMEOUT]  = 1000;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, on reset settings.
        read_px(0, 0);                               // read while free
        poll(1'b0, 12'd0, 12'd0, 32'd5);              // pen-up while free
        poll(1'b1, 12'd0, 12'd0, 32'd0);              // corner: square partly off image
        poll(1'b1, 12'hFFF, 12'hFFF, 32'd0);          // far corner
        poll(1'b1, 12'd2048, 12'd0, 32'd0);           // left edge, mid height
        read_px(0, 0);                               // read while dirty
        poll(1'b0, 12'd0, 12'd0, 32'd1000);           // at the deadline, not past
        poll(1'b0, 12'hFFF, 12'hFFF, 32'd1001);       // past it: ready
        poll(1'b1, 12'd100, 12'd100, 32'd2000);       // ignored while ready
        poll(1'b0, 12'd0, 12'd0, 32'd5000);           // ignored while ready
        read_px(0, 0);
        read_px(69, 69);
        read_px(1, 1);
        read_px(2, 2);
        read_px(70, 0);                              // outside the image
        read_px(127, 127);
        read_px(0, 35);
        send_cmd(make_cmd(KIND_UNUSED, 1'b1, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF,
                          7'h7F, 7'h7F));
        free_img();
        read_px(0, 0);
        poll(1'b1, 12'd2048, 12'd2048, 32'hFFFF_FFFF); // deadline above 32 bits
        poll(1'b0, 12'd0, 12'd0, 32'hFFFF_FFFF);
        free_img();

        // Random part over several register settings, extremes included.
        run_phase(0, 0, 4096, 4096, 1000);
        run_phase(4095, 4095, 1, 1, 0);
        run_phase(0, 0, 0, 0, 65535);
        run_phase($urandom_range(0, 2000), $urandom_range(0, 2000),
                  $urandom_range(1000, 4096), $urandom_range(1000, 4096),
                  $urandom_range(0, 100));
        run_phase(1000, 500, 8191, 70, 5);
        run_phase($urandom_range(0, 4095), $urandom_range(0, 4095),
                  $urandom_range(1, 8191), $urandom_range(1, 8191),
                  $urandom_range(0, 65535));

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        tracker.check_drained();
        if (tracker.errors == 0)
            $display("touch_stroke_bitmap_capture: match");
        else
            $display("touch_stroke_bitmap_capture: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
design/tsbc_pkg.sv
design/touch_stroke_bitmap_capture.sv
design/tsbc_checker.sv
tb/sv/touch_stroke_bitmap_capture_test.sv
